/* rtl/core/ubldm_pkg.sv */
// ubldm_pkg: shared types and constants of the byte-lane data memory.
// Depends on nothing; used by ubldm_addr_stage, ubldm_load_align and the top level.
`timescale 1ns / 1ps

package ubldm_pkg;

	localparam int unsigned NUM_LANES   = 4;
	localparam int unsigned LANE_W      = 8;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned ADDR_W      = 12;
	localparam int unsigned OFFSET_W    = 2;
	localparam int unsigned WORD_IDX_W  = ADDR_W - OFFSET_W;

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	// access size codes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;
	localparam logic [1:0] SIZE_RSVD = 2'd3;

	typedef logic [NUM_LANES-1:0][LANE_W-1:0] lane_bytes_t;

	// control of one access as it leaves the address stage
	typedef struct packed {
		logic                valid;
		logic                is_load;
		logic [OFFSET_W-1:0] offset;
		logic [1:0]          size;
		logic                zext;
	} acc_ctrl_t;

endpackage

/* rtl/core/ubldm_lane_ram.sv */
// ubldm_lane_ram: one byte-wide lane of the data memory, single port,
// registered read. Depends on nothing.
`timescale 1ns / 1ps

module ubldm_lane_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IDX_W = 10,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/ubldm_addr_stage.sv */
// ubldm_addr_stage: input register of an access, per-lane entry index,
// store byte steering and lane write enables. Depends on ubldm_pkg.
`timescale 1ns / 1ps

module ubldm_addr_stage #(
	parameter int unsigned WORDS_PER_LANE = 1024,
	parameter int unsigned IDX_W          = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic                                   operation,
	input  logic [ubldm_pkg::ADDR_W-1:0]           byte_address,
	input  logic [ubldm_pkg::DATA_W-1:0]           store_data,
	input  logic [1:0]                             access_size,
	input  logic                                   zero_extend,
	output logic [ubldm_pkg::NUM_LANES-1:0][IDX_W-1:0] lane_idx,
	output logic [ubldm_pkg::NUM_LANES-1:0]        lane_we,
	output ubldm_pkg::lane_bytes_t                 lane_wdata,
	output ubldm_pkg::acc_ctrl_t                   ctrl
);

	import ubldm_pkg::*;

	logic                  valid_s1;
	logic                  op_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [DATA_W-1:0]     data_s1;
	logic [1:0]            size_s1;
	logic                  zext_s1;

	logic [WORD_IDX_W-1:0] word_s1;
	logic [OFFSET_W-1:0]   off_s1;
	logic [IDX_W-1:0]      idx_cur;
	logic [IDX_W-1:0]      idx_nxt;

	// beat capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			addr_s1 <= byte_address;
			data_s1 <= store_data;
			size_s1 <= access_size;
			zext_s1 <= zero_extend;
		end
	end

	assign word_s1 = addr_s1[ADDR_W-1:OFFSET_W];
	assign off_s1  = addr_s1[OFFSET_W-1:0];

	// word index modulo lane depth
	generate
		if (WORDS_PER_LANE >= (2 ** WORD_IDX_W)) begin : g_no_fold
			assign idx_cur = IDX_W'(word_s1);
		end else begin : g_fold
			// quotient by reciprocal multiply, exact for all word indices
			localparam int unsigned SHIFT  = WORD_IDX_W + IDX_W;
			localparam int unsigned RECIP  = ((2 ** SHIFT) + WORDS_PER_LANE - 1)
				/ WORDS_PER_LANE;
			localparam int unsigned RECIP_W = WORD_IDX_W + 2;
			localparam int unsigned PROD_W  = WORD_IDX_W + RECIP_W;
			localparam logic [RECIP_W-1:0]    RECIP_C = RECIP_W'(RECIP);
			localparam logic [WORD_IDX_W-1:0] DEPTH_C = WORD_IDX_W'(WORDS_PER_LANE);

			logic [PROD_W-1:0]     prod;
			logic [WORD_IDX_W-1:0] quot;
			logic [WORD_IDX_W-1:0] rem;

			assign prod    = PROD_W'(word_s1) * PROD_W'(RECIP_C);
			assign quot    = WORD_IDX_W'(prod >> SHIFT);
			assign rem     = word_s1 - WORD_IDX_W'(quot * DEPTH_C);
			assign idx_cur = rem[IDX_W-1:0];
		end
	endgenerate

	// following word, wrapping at the last entry
	assign idx_nxt = (idx_cur == IDX_W'(WORDS_PER_LANE - 1)) ? '0 : idx_cur + 1'b1;

	// per-lane index, byte steering and enables
	always_comb begin
		logic [OFFSET_W-1:0] bpos;
		logic                en;
		for (int l = 0; l < NUM_LANES; l++) begin
			bpos = OFFSET_W'(l) - off_s1;
			lane_idx[l] = (OFFSET_W'(l) < off_s1) ? idx_nxt : idx_cur;
			lane_wdata[l] = data_s1[bpos*LANE_W +: LANE_W];
			en = (bpos == 2'd0)
				|| (bpos == 2'd1 && size_s1 != SIZE_BYTE)
				|| (size_s1 == SIZE_WORD) || (size_s1 == SIZE_RSVD);
			lane_we[l] = valid_s1 && (op_s1 == OP_STORE) && en;
		end
	end

	assign ctrl.valid   = valid_s1;
	assign ctrl.is_load = (op_s1 == OP_LOAD);
	assign ctrl.offset  = off_s1;
	assign ctrl.size    = size_s1;
	assign ctrl.zext    = zext_s1;

endmodule

/* rtl/core/ubldm_load_align.sv */
// ubldm_load_align: rotates lane read data into the loaded word, extends it
// and holds the result register. Depends on ubldm_pkg.
`timescale 1ns / 1ps

module ubldm_load_align (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ubldm_pkg::acc_ctrl_t         ctrl,
	input  ubldm_pkg::lane_bytes_t       rd,
	output logic                         valid,
	output logic [ubldm_pkg::DATA_W-1:0] load_data
);

	import ubldm_pkg::*;

	acc_ctrl_t          ctrl_s2;
	logic [DATA_W-1:0]  word;
	logic [DATA_W-1:0]  ext;
	logic               valid_q;
	logic [DATA_W-1:0]  load_data_q;

	// control is registered in step with the lane read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl;
		end
	end

	// byte i comes from lane (offset + i) mod 4
	always_comb begin
		logic [OFFSET_W-1:0] sel;
		for (int i = 0; i < NUM_LANES; i++) begin
			sel = ctrl_s2.offset + OFFSET_W'(i);
			word[i*LANE_W +: LANE_W] = rd[sel];
		end
	end

	// size and extension
	always_comb begin
		case (ctrl_s2.size)
			SIZE_BYTE: ext = {{24{word[7] & ~ctrl_s2.zext}}, word[7:0]};
			SIZE_HALF: ext = {{16{word[15] & ~ctrl_s2.zext}}, word[15:0]};
			SIZE_WORD: ext = word;
			default:   ext = '0;
		endcase
	end

	// result register; stores report zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		load_data_q <= ctrl_s2.is_load ? ext : '0;
	end

	assign valid     = valid_q;
	assign load_data = load_data_q;

endmodule

/* rtl/core/unaligned_byte_lane_data_memory.sv */
// unaligned_byte_lane_data_memory: top level, four byte lanes with clearing
// pass. Depends on ubldm_pkg, ubldm_addr_stage, ubldm_lane_ram, ubldm_load_align.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  access   | start & !busy      | operation, byte_address, store_data,
//           |                    | access_size, zero_extend
//  result   | valid (one cycle)  | load_data
//
// One access is accepted per cycle while busy is low; its result passes the
// input register, the lane memory read register and the result register.
// After reset a clearing pass writes zero to every entry, with busy high;
// no access is accepted during it.
// The result strobe cannot be held off; every accepted beat yields one.
`timescale 1ns / 1ps

module unaligned_byte_lane_data_memory #(
	parameter int unsigned WORDS_PER_LANE = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [ubldm_pkg::ADDR_W-1:0] byte_address,
	input  logic [ubldm_pkg::DATA_W-1:0] store_data,
	input  logic [1:0]                   access_size,
	input  logic                         zero_extend,
	output logic                         valid,
	output logic [ubldm_pkg::DATA_W-1:0] load_data
);

	import ubldm_pkg::*;

	localparam int unsigned IDX_W = $clog2(WORDS_PER_LANE);

	logic                              accept;
	logic                              clr_active_q;
	logic [IDX_W-1:0]                  clr_idx_q;
	logic [NUM_LANES-1:0][IDX_W-1:0]   lane_idx;
	logic [NUM_LANES-1:0]              lane_we;
	lane_bytes_t                       lane_wdata;
	lane_bytes_t                       lane_rd;
	acc_ctrl_t                         ctrl;

	assign accept = start && !clr_active_q;
	assign busy   = clr_active_q;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(WORDS_PER_LANE - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	ubldm_addr_stage #(
		.WORDS_PER_LANE (WORDS_PER_LANE),
		.IDX_W          (IDX_W)
	) u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.byte_address (byte_address),
		.store_data   (store_data),
		.access_size  (access_size),
		.zero_extend  (zero_extend),
		.lane_idx     (lane_idx),
		.lane_we      (lane_we),
		.lane_wdata   (lane_wdata),
		.ctrl         (ctrl)
	);

	// lane memories; clearing pass takes the port while active
	generate
		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			logic             we;
			logic [IDX_W-1:0] addr;
			logic [LANE_W-1:0] wdata;

			assign we    = clr_active_q || lane_we[l];
			assign addr  = clr_active_q ? clr_idx_q : lane_idx[l];
			assign wdata = clr_active_q ? '0 : lane_wdata[l];

			ubldm_lane_ram #(
				.DEPTH (WORDS_PER_LANE),
				.IDX_W (IDX_W),
				.WIDTH (LANE_W)
			) u_ram (
				.clk   (clk),
				.we    (we),
				.addr  (addr),
				.wdata (wdata),
				.rdata (lane_rd[l])
			);
		end
	endgenerate

	ubldm_load_align u_align (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.rd        (lane_rd),
		.valid     (valid),
		.load_data (load_data)
	);

`ifndef SYNTHESIS
	// every accepted beat gives exactly one result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 valid)
		else $error("accepted beat produced no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(accept, 3))
		else $error("result without an accepted beat");

	// a store reports zero
	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_STORE |-> ##3 (load_data == '0))
		else $error("store returned nonzero data");

	// no lane write from an access while clearing
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> (lane_we == '0) && !ctrl.valid)
		else $error("access overlapped the clearing pass");
`endif

endmodule
